// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL modules of the byte range parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("same-cycle implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("next-cycle implication check failed");

`endif

// File: hw/rtl/hbrp_pkg.sv
// Package with the types, constants and helper functions of the byte range parser.
`timescale 1ns / 1ps
`default_nettype none

package hbrp_pkg;

    localparam int OFFSET_BITS_DEF     = 48;
    localparam int MAX_RANGE_COUNT_DEF = 16;
    localparam int FIELD_BITS          = 48;

    localparam int PREFIX_LEN = 5;
    localparam int MIN_LEN    = 7;

    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_BIT   = 8'h20;

    typedef enum logic [3:0] {
        PH_PREFIX    = 4'd0,
        PH_EQ        = 4'd1,
        PH_AFTER_EQ  = 4'd2,
        PH_FIRST     = 4'd3,
        PH_WS_FIRST  = 4'd4,
        PH_DASH      = 4'd5,
        PH_LAST      = 4'd6,
        PH_WS_LAST   = 4'd7,
        PH_COMMA     = 4'd8,
        PH_SUF_START = 4'd9,
        PH_SUF       = 4'd10,
        PH_WS_SUF    = 4'd11
    } phase_t;

    typedef enum logic [1:0] {
        EMIT_NONE   = 2'd0,
        EMIT_OPEN   = 2'd1,
        EMIT_CLOSED = 2'd2,
        EMIT_SUFFIX = 2'd3
    } emit_kind_t;

    typedef struct packed {
        logic                  hit;
        logic                  reversed;
        logic [FIELD_BITS-1:0] range_lo;
        logic [FIELD_BITS-1:0] range_hi;
    } emit_res_t;

    typedef struct packed {
        logic                  range_valid;
        logic [FIELD_BITS-1:0] range_start;
        logic [FIELD_BITS-1:0] range_end;
        logic                  done_res;
        logic                  accepted;
    } result_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB);
    endfunction

    function automatic logic is_numeral(input logic [7:0] c);
        return c inside {[CH_ZERO:CH_NINE]};
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c inside {[CH_UPPER_A:CH_UPPER_Z]}) ? (c | CASE_BIT) : c;
    endfunction

    // Lower-case letters of the unit name "bytes".
    function automatic logic [7:0] prefix_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h62;
            3'd1:    ch = 8'h79;
            3'd2:    ch = 8'h74;
            3'd3:    ch = 8'h65;
            3'd4:    ch = 8'h73;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/hbrp_digit_acc.sv
// Decimal accumulator: value times ten plus one digit, with overflow detection.
`timescale 1ns / 1ps
`default_nettype none

module hbrp_digit_acc #(
    parameter int OFFSET_BITS = hbrp_pkg::OFFSET_BITS_DEF
) (
    input  wire logic [OFFSET_BITS-1:0] acc_in,
    input  wire logic [3:0]             digit,
    output logic      [OFFSET_BITS-1:0] acc_out,
    output logic                        overflow
);

    logic [OFFSET_BITS+3:0] wide_in;
    logic [OFFSET_BITS+3:0] sum;

    // Times ten is done as times eight plus times two; four guard bits hold the carry.
    assign wide_in  = {4'b0000, acc_in};
    assign sum      = (wide_in << 3) + (wide_in << 1) + (OFFSET_BITS+4)'(digit);
    assign acc_out  = sum[OFFSET_BITS-1:0];
    assign overflow = |sum[OFFSET_BITS+3:OFFSET_BITS];

endmodule

`default_nettype wire

// File: hw/rtl/hbrp_range_emit.sv
// Clamps one completed range spec to the file size and checks that it can be met.
`timescale 1ns / 1ps
`default_nettype none

module hbrp_range_emit #(
    parameter int OFFSET_BITS = hbrp_pkg::OFFSET_BITS_DEF
) (
    input  wire hbrp_pkg::emit_kind_t                kind,
    input  wire logic [OFFSET_BITS-1:0]              first_offset,
    input  wire logic [OFFSET_BITS-1:0]              last_offset,
    input  wire logic [OFFSET_BITS-1:0]              suffix_length,
    input  wire logic [hbrp_pkg::FIELD_BITS-1:0]     file_size,
    output hbrp_pkg::emit_res_t                      res
);

    localparam int CW = (OFFSET_BITS > hbrp_pkg::FIELD_BITS) ? OFFSET_BITS
                                                            : hbrp_pkg::FIELD_BITS;

    logic [CW-1:0] fs_w;
    logic [CW-1:0] first_w;
    logic [CW-1:0] last_w;
    logic [CW-1:0] suf_w;
    logic [CW-1:0] fs_m1;
    logic [CW-1:0] lo_w;
    logic [CW-1:0] hi_w;
    logic          first_in;

    assign fs_w     = CW'(file_size);
    assign first_w  = CW'(first_offset);
    assign last_w   = CW'(last_offset);
    assign suf_w    = CW'(suffix_length);
    assign fs_m1    = fs_w - CW'(1);
    assign first_in = first_w < fs_w;

    always_comb
    begin
        res.hit      = 1'b0;
        res.reversed = 1'b0;
        lo_w         = first_w;
        hi_w         = fs_m1;
        case (kind)
            hbrp_pkg::EMIT_OPEN:
            begin
                res.hit = first_in;
            end
            hbrp_pkg::EMIT_CLOSED:
            begin
                res.reversed = first_w > last_w;
                res.hit      = first_in && !res.reversed;
                hi_w         = (last_w < fs_w) ? last_w : fs_m1;
            end
            hbrp_pkg::EMIT_SUFFIX:
            begin
                res.hit = (suf_w != '0) && (fs_w != '0);
                lo_w    = (fs_w > suf_w) ? (fs_w - suf_w) : '0;
            end
            default:
            begin
                res.hit = 1'b0;
            end
        endcase
        // A range that is met always lies below the file size, so it fits the port width.
        res.range_lo = lo_w[hbrp_pkg::FIELD_BITS-1:0];
        res.range_hi = hi_w[hbrp_pkg::FIELD_BITS-1:0];
    end

endmodule

`default_nettype wire

// File: hw/rtl/hbrp_parser.sv
// Parse state machine: header phase, byte count, offsets, range count and sticky failure.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module hbrp_parser #(
    parameter int OFFSET_BITS     = hbrp_pkg::OFFSET_BITS_DEF,
    parameter int MAX_RANGE_COUNT = hbrp_pkg::MAX_RANGE_COUNT_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            step,
    input  wire logic [7:0]                      value_byte,
    input  wire logic                            last_byte,
    input  wire logic [hbrp_pkg::FIELD_BITS-1:0] file_size,
    output hbrp_pkg::result_t                    result
);

    localparam int CNT_W = $clog2(MAX_RANGE_COUNT + 1);

    hbrp_pkg::phase_t       phase_reg, phase_next;
    logic [2:0]             pos_reg, pos_next;
    logic [OFFSET_BITS-1:0] first_reg, first_next;
    logic [OFFSET_BITS-1:0] last_reg, last_next;
    logic [OFFSET_BITS-1:0] suffix_reg, suffix_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   failed_reg, failed_next;

    hbrp_pkg::phase_t       phase_upd;
    logic [OFFSET_BITS-1:0] first_upd;
    logic [OFFSET_BITS-1:0] last_upd;
    logic [OFFSET_BITS-1:0] suffix_upd;
    logic                   fail_upd;

    logic [7:0]             lc;
    logic [3:0]             digit;
    logic                   c_dig;
    logic                   c_ws;
    logic [OFFSET_BITS-1:0] acc_in;
    logic [OFFSET_BITS-1:0] acc_out;
    logic                   acc_ovf;
    hbrp_pkg::emit_kind_t   kind;
    hbrp_pkg::emit_res_t    em;
    logic                   em_valid;
    logic                   restart_clean;

    assign lc    = hbrp_pkg::to_lower(value_byte);
    assign digit = 4'(value_byte - hbrp_pkg::CH_ZERO);
    assign c_dig = hbrp_pkg::is_numeral(value_byte);
    assign c_ws  = hbrp_pkg::is_ws(value_byte);

    // Only one number grows per byte, so one accumulator serves all three.
    assign acc_in = (phase_reg == hbrp_pkg::PH_LAST) ? last_reg :
                    (phase_reg == hbrp_pkg::PH_SUF)  ? suffix_reg : first_reg;

    hbrp_digit_acc #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_acc (
        .acc_in  (acc_in),
        .digit   (digit),
        .acc_out (acc_out),
        .overflow(acc_ovf)
    );

    // The range check sees the numbers as updated by this byte, before the
    // end-of-header clear.
    hbrp_range_emit #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_emit (
        .kind         (kind),
        .first_offset (first_upd),
        .last_offset  (last_upd),
        .suffix_length(suffix_upd),
        .file_size    (file_size),
        .res          (em)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= hbrp_pkg::PH_PREFIX;
            pos_reg    <= '0;
            first_reg  <= '0;
            last_reg   <= '0;
            suffix_reg <= '0;
            count_reg  <= '0;
            failed_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            first_reg  <= first_next;
            last_reg   <= last_next;
            suffix_reg <= suffix_next;
            count_reg  <= count_next;
            failed_reg <= failed_next;
        end
    end

    always_comb
    begin
        phase_upd  = phase_reg;
        first_upd  = first_reg;
        last_upd   = last_reg;
        suffix_upd = suffix_reg;
        fail_upd   = failed_reg;
        kind       = hbrp_pkg::EMIT_NONE;

        if (!failed_reg)
        begin
            case (phase_reg)
                hbrp_pkg::PH_PREFIX:
                begin
                    if ((32'(pos_reg) >= hbrp_pkg::PREFIX_LEN) ||
                        (lc != hbrp_pkg::prefix_char(pos_reg)))
                        fail_upd = 1'b1;
                    else if (pos_reg == 3'(hbrp_pkg::PREFIX_LEN - 1))
                        phase_upd = hbrp_pkg::PH_EQ;
                end
                hbrp_pkg::PH_EQ:
                begin
                    if (value_byte == hbrp_pkg::CH_EQ)
                        phase_upd = hbrp_pkg::PH_AFTER_EQ;
                    else if (!c_ws)
                        fail_upd = 1'b1;
                end
                hbrp_pkg::PH_AFTER_EQ, hbrp_pkg::PH_COMMA:
                begin
                    if (c_dig)
                    begin
                        first_upd = OFFSET_BITS'(digit);
                        phase_upd = hbrp_pkg::PH_FIRST;
                    end
                    else if (value_byte == hbrp_pkg::CH_DASH)
                        phase_upd = hbrp_pkg::PH_SUF_START;
                    else if (!c_ws)
                        fail_upd = 1'b1;
                end
                hbrp_pkg::PH_FIRST:
                begin
                    if (c_dig)
                    begin
                        if (acc_ovf)
                            fail_upd = 1'b1;
                        else
                            first_upd = acc_out;
                    end
                    else if (value_byte == hbrp_pkg::CH_DASH)
                        phase_upd = hbrp_pkg::PH_DASH;
                    else if (c_ws)
                        phase_upd = hbrp_pkg::PH_WS_FIRST;
                    else
                        fail_upd = 1'b1;
                end
                hbrp_pkg::PH_WS_FIRST:
                begin
                    if (value_byte == hbrp_pkg::CH_DASH)
                        phase_upd = hbrp_pkg::PH_DASH;
                    else if (!c_ws)
                        fail_upd = 1'b1;
                end
                hbrp_pkg::PH_DASH:
                begin
                    if (c_dig)
                    begin
                        last_upd  = OFFSET_BITS'(digit);
                        phase_upd = hbrp_pkg::PH_LAST;
                    end
                    else if (value_byte == hbrp_pkg::CH_COMMA)
                    begin
                        kind      = hbrp_pkg::EMIT_OPEN;
                        phase_upd = hbrp_pkg::PH_COMMA;
                    end
                    else if (!c_ws)
                        fail_upd = 1'b1;
                end
                hbrp_pkg::PH_LAST:
                begin
                    if (c_dig)
                    begin
                        if (acc_ovf)
                            fail_upd = 1'b1;
                        else
                            last_upd = acc_out;
                    end
                    else if (value_byte == hbrp_pkg::CH_COMMA)
                    begin
                        kind      = hbrp_pkg::EMIT_CLOSED;
                        phase_upd = hbrp_pkg::PH_COMMA;
                    end
                    else if (c_ws)
                    begin
                        kind      = hbrp_pkg::EMIT_CLOSED;
                        phase_upd = hbrp_pkg::PH_WS_LAST;
                    end
                    else
                        fail_upd = 1'b1;
                end
                hbrp_pkg::PH_WS_LAST, hbrp_pkg::PH_WS_SUF:
                begin
                    if (value_byte == hbrp_pkg::CH_COMMA)
                        phase_upd = hbrp_pkg::PH_COMMA;
                    else if (!c_ws)
                        fail_upd = 1'b1;
                end
                hbrp_pkg::PH_SUF_START:
                begin
                    if (c_dig)
                    begin
                        suffix_upd = OFFSET_BITS'(digit);
                        phase_upd  = hbrp_pkg::PH_SUF;
                    end
                    else if (!c_ws)
                        fail_upd = 1'b1;
                end
                hbrp_pkg::PH_SUF:
                begin
                    if (c_dig)
                    begin
                        if (acc_ovf)
                            fail_upd = 1'b1;
                        else
                            suffix_upd = acc_out;
                    end
                    else if (value_byte == hbrp_pkg::CH_COMMA)
                    begin
                        kind      = hbrp_pkg::EMIT_SUFFIX;
                        phase_upd = hbrp_pkg::PH_COMMA;
                    end
                    else if (c_ws)
                    begin
                        kind      = hbrp_pkg::EMIT_SUFFIX;
                        phase_upd = hbrp_pkg::PH_WS_SUF;
                    end
                    else
                        fail_upd = 1'b1;
                end
                default:
                begin
                    fail_upd = 1'b1;
                end
            endcase
        end

        // On the last byte the pending spec is closed out. A byte that already
        // completed a spec leaves a phase here that needs no further range.
        if (last_byte)
        begin
            if (32'(pos_reg) < hbrp_pkg::MIN_LEN - 1)
                fail_upd = 1'b1;
            if (!fail_upd)
            begin
                case (phase_upd)
                    hbrp_pkg::PH_DASH:   kind = hbrp_pkg::EMIT_OPEN;
                    hbrp_pkg::PH_LAST:   kind = hbrp_pkg::EMIT_CLOSED;
                    hbrp_pkg::PH_SUF:    kind = hbrp_pkg::EMIT_SUFFIX;
                    hbrp_pkg::PH_WS_LAST,
                    hbrp_pkg::PH_WS_SUF:
                    begin
                    end
                    default:             fail_upd = 1'b1;
                endcase
            end
        end
    end

    always_comb
    begin
        failed_next = fail_upd;
        count_next  = count_reg;
        em_valid    = 1'b0;

        if (kind != hbrp_pkg::EMIT_NONE)
        begin
            if (em.reversed)
                failed_next = 1'b1;
            else if (em.hit)
            begin
                if (count_reg >= CNT_W'(MAX_RANGE_COUNT))
                    failed_next = 1'b1;
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                    em_valid   = 1'b1;
                end
            end
        end

        phase_next  = phase_upd;
        first_next  = first_upd;
        last_next   = last_upd;
        suffix_next = suffix_upd;
        pos_next    = (&pos_reg) ? pos_reg : pos_reg + 3'd1;

        result.range_valid = em_valid && !failed_next;
        result.range_start = result.range_valid ? em.range_lo : '0;
        result.range_end   = result.range_valid ? em.range_hi : '0;
        result.done_res    = last_byte;
        result.accepted    = last_byte && !failed_next;

        if (last_byte)
        begin
            phase_next  = hbrp_pkg::PH_PREFIX;
            pos_next    = '0;
            first_next  = '0;
            last_next   = '0;
            suffix_next = '0;
            count_next  = '0;
            failed_next = 1'b0;
        end
    end

    assign restart_clean = (phase_reg == hbrp_pkg::PH_PREFIX) && (pos_reg == 3'd0) &&
                           (count_reg == '0) && !failed_reg;

    `ASSERT_IMPLY(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(MAX_RANGE_COUNT))
    `ASSERT_NEXT(a_header_restart, clk, rst_n, step && last_byte, restart_clean)

endmodule

`default_nettype wire

// File: hw/rtl/http_byte_range_parser_unit.sv
// Usage notes:
// Streaming parser for the value of an HTTP Range header, one byte per transaction.
// The config channel (cfg_valid, cfg_ready, file_size) loads the resource size; it
// is always ready and must be written only while no header byte is in flight.
// Header bytes enter on in_valid/in_ready with value_byte and last_byte. Every byte
// yields exactly one result transaction on out_valid/out_ready carrying
// range_valid, range_start, range_end, done_res and accepted.
// A byte taken into the input register is parsed combinationally and written to the
// result register once that register can advance, and its result is then offered.
// Throughput is one byte per cycle while out_ready holds high, set by the
// combinational parse step between the input register and the result register.
// A range is shown on the byte that completes it. On the byte flagged last,
// done_res is set and accepted tells whether the whole header parsed; when it
// is clear, the ranges already delivered for that header are to be dropped.
// When out_ready is low the result register holds its transaction and the input
// register still takes one more byte; after that in_ready drops until the
// receiver drains. Reset clears the parse state, both stage valids and file_size.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module http_byte_range_parser_unit #(
    parameter int OFFSET_BITS     = hbrp_pkg::OFFSET_BITS_DEF,
    parameter int MAX_RANGE_COUNT = hbrp_pkg::MAX_RANGE_COUNT_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [hbrp_pkg::FIELD_BITS-1:0] file_size,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [7:0]                      value_byte,
    input  wire logic                            last_byte,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic                                 range_valid,
    output logic [hbrp_pkg::FIELD_BITS-1:0]      range_start,
    output logic [hbrp_pkg::FIELD_BITS-1:0]      range_end,
    output logic                                 done_res,
    output logic                                 accepted
);

    logic [hbrp_pkg::FIELD_BITS-1:0] fsize_reg;
    logic                            in_vld_reg, in_vld_next;
    logic [7:0]                      byte_reg;
    logic                            lastb_reg;
    logic                            out_vld_reg, out_vld_next;
    hbrp_pkg::result_t               res_reg;
    hbrp_pkg::result_t               res_next;
    logic                            advance;
    logic                            step;

    assign cfg_ready = 1'b1;
    assign advance   = !out_vld_reg || out_ready;
    assign in_ready  = !in_vld_reg || advance;
    assign step      = in_vld_reg && advance;

    hbrp_parser #(
        .OFFSET_BITS    (OFFSET_BITS),
        .MAX_RANGE_COUNT(MAX_RANGE_COUNT)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .value_byte(byte_reg),
        .last_byte (lastb_reg),
        .file_size (fsize_reg),
        .result    (res_next)
    );

    always_comb
    begin
        in_vld_next  = in_ready ? in_valid : in_vld_reg;
        out_vld_next = advance ? in_vld_reg : out_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsize_reg   <= '0;
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                fsize_reg <= file_size;
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg  <= value_byte;
            lastb_reg <= last_byte;
        end
        if (step)
            res_reg <= res_next;
    end

    assign out_valid   = out_vld_reg;
    assign range_valid = res_reg.range_valid;
    assign range_start = res_reg.range_start;
    assign range_end   = res_reg.range_end;
    assign done_res    = res_reg.done_res;
    assign accepted    = res_reg.accepted;

    `ASSERT_IMPLY(a_range_order, clk, rst_n, out_valid && range_valid, range_start <= range_end)
    `ASSERT_IMPLY(a_status_on_last, clk, rst_n, out_valid && accepted, done_res)
    `ASSERT_IMPLY(a_reject_no_range, clk, rst_n, out_valid && done_res && !accepted, !range_valid)

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for the HTTP byte range parser unit.
`timescale 1ns / 1ps

module tb_top;
    import hbrp_pkg::*;

    localparam logic [63:0] OFFSET_MAX  = (64'd1 << OFFSET_BITS_DEF) - 64'd1;
    localparam logic [39:0] UNIT_WORD   = "bytes";
    localparam int          LONG_STALL  = 150;
    localparam int          QUIET_LIMIT = 2000;
    localparam int          PHASE_BYTES = 150;

    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
    } header_byte_t;

    logic                  clk;
    logic                  rst_n       = 1'b0;
    logic                  cfg_valid   = 1'b0;
    logic                  cfg_ready;
    logic [FIELD_BITS-1:0] file_size   = '0;
    logic                  in_valid    = 1'b0;
    logic                  in_ready;
    logic [7:0]            value_byte  = '0;
    logic                  last_byte   = 1'b0;
    logic                  out_valid;
    logic                  out_ready   = 1'b0;
    logic                  range_valid;
    logic [FIELD_BITS-1:0] range_start;
    logic [FIELD_BITS-1:0] range_end;
    logic                  done_res;
    logic                  accepted;

    header_byte_t pending_bytes[$];
    result_t      expected_results[$];
    logic [7:0]   draft[$];
    int           bytes_queued   = 0;
    int           mismatch_count = 0;
    int           in_gap_max     = 5;
    int           out_wait_max   = 5;
    int           send_gap       = 0;
    int           rx_wait        = 0;
    int           stall_left     = 0;
    int           stall_requests = 0;
    int           stalls_begun   = 0;
    int           quiet_cycles   = 0;

    // Parser state as the design should hold it.
    phase_t       scan_phase    = PH_PREFIX;
    int unsigned  scan_count    = 0;
    logic [63:0]  first_num     = '0;
    logic [63:0]  last_num      = '0;
    logic [63:0]  suffix_num    = '0;
    int unsigned  ranges_taken  = 0;
    logic         parse_broken  = 1'b0;
    logic         range_hit     = 1'b0;
    logic [63:0]  range_lo      = '0;
    logic [63:0]  range_hi      = '0;
    logic [63:0]  resource_size = '0;

    http_byte_range_parser_unit uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .file_size  (file_size),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .value_byte (value_byte),
        .last_byte  (last_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .range_valid(range_valid),
        .range_start(range_start),
        .range_end  (range_end),
        .done_res   (done_res),
        .accepted   (accepted)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic blank_char(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB);
    endfunction

    function automatic logic dec_char(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // Decimal accumulation; a value past the offset width breaks the parse.
    function automatic logic [63:0] add_digit(input logic [63:0] acc, input logic [7:0] c);
        logic [63:0] d;
        d = c - CH_ZERO;
        if (acc > (OFFSET_MAX - d) / 10)
        begin
            parse_broken = 1'b1;
            return acc;
        end
        return acc * 10 + d;
    endfunction

    function automatic void take_range(input logic [63:0] lo, input logic [63:0] hi);
        if (ranges_taken >= MAX_RANGE_COUNT_DEF)
            parse_broken = 1'b1;
        else
        begin
            ranges_taken++;
            range_hit = 1'b1;
            range_lo  = lo;
            range_hi  = hi;
        end
    endfunction

    function automatic void close_open_range();
        if (first_num < resource_size)
            take_range(first_num, resource_size - 1);
    endfunction

    function automatic void close_pair_range();
        if (first_num > last_num)
            parse_broken = 1'b1;
        else if (first_num < resource_size)
            take_range(first_num, (last_num < resource_size - 1) ? last_num : resource_size - 1);
    endfunction

    function automatic void close_suffix_range();
        if (suffix_num != 0 && resource_size != 0)
            take_range((resource_size > suffix_num) ? resource_size - suffix_num : 64'd0,
                       resource_size - 1);
    endfunction

    // Advances the parser by one header byte and returns the result it should produce.
    function automatic result_t predict_range_result(input logic [7:0] c, input logic fin);
        result_t    r;
        logic [7:0] lc;
        range_hit = 1'b0;
        range_lo  = '0;
        range_hi  = '0;
        if (!parse_broken)
        begin
            case (scan_phase)
                PH_PREFIX:
                begin
                    lc = (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? (c | CASE_BIT) : c;
                    if (scan_count >= PREFIX_LEN)
                        parse_broken = 1'b1;
                    else if (lc != UNIT_WORD[39 - 8 * scan_count -: 8])
                        parse_broken = 1'b1;
                    else if (scan_count == PREFIX_LEN - 1)
                        scan_phase = PH_EQ;
                end
                PH_EQ:
                    if (c == CH_EQ) scan_phase = PH_AFTER_EQ;
                    else if (!blank_char(c)) parse_broken = 1'b1;
                PH_AFTER_EQ, PH_COMMA:
                    if (dec_char(c))
                    begin
                        first_num  = c - CH_ZERO;
                        scan_phase = PH_FIRST;
                    end
                    else if (c == CH_DASH) scan_phase = PH_SUF_START;
                    else if (!blank_char(c)) parse_broken = 1'b1;
                PH_FIRST:
                    if (dec_char(c)) first_num = add_digit(first_num, c);
                    else if (c == CH_DASH) scan_phase = PH_DASH;
                    else if (blank_char(c)) scan_phase = PH_WS_FIRST;
                    else parse_broken = 1'b1;
                PH_WS_FIRST:
                    if (c == CH_DASH) scan_phase = PH_DASH;
                    else if (!blank_char(c)) parse_broken = 1'b1;
                PH_DASH:
                    if (dec_char(c))
                    begin
                        last_num   = c - CH_ZERO;
                        scan_phase = PH_LAST;
                    end
                    else if (c == CH_COMMA)
                    begin
                        close_open_range();
                        scan_phase = PH_COMMA;
                    end
                    else if (!blank_char(c)) parse_broken = 1'b1;
                PH_LAST:
                    if (dec_char(c)) last_num = add_digit(last_num, c);
                    else if (c == CH_COMMA)
                    begin
                        close_pair_range();
                        scan_phase = PH_COMMA;
                    end
                    else if (blank_char(c))
                    begin
                        close_pair_range();
                        scan_phase = PH_WS_LAST;
                    end
                    else parse_broken = 1'b1;
                PH_WS_LAST, PH_WS_SUF:
                    if (c == CH_COMMA) scan_phase = PH_COMMA;
                    else if (!blank_char(c)) parse_broken = 1'b1;
                PH_SUF_START:
                    if (dec_char(c))
                    begin
                        suffix_num = c - CH_ZERO;
                        scan_phase = PH_SUF;
                    end
                    else if (!blank_char(c)) parse_broken = 1'b1;
                PH_SUF:
                    if (dec_char(c)) suffix_num = add_digit(suffix_num, c);
                    else if (c == CH_COMMA)
                    begin
                        close_suffix_range();
                        scan_phase = PH_COMMA;
                    end
                    else if (blank_char(c))
                    begin
                        close_suffix_range();
                        scan_phase = PH_WS_SUF;
                    end
                    else parse_broken = 1'b1;
                default:
                    parse_broken = 1'b1;
            endcase
        end
        if (fin)
        begin
            if (scan_count < MIN_LEN - 1)
                parse_broken = 1'b1;
            if (!parse_broken)
            begin
                // A spec still open at the end is closed by the last byte.
                case (scan_phase)
                    PH_DASH:              close_open_range();
                    PH_LAST:              close_pair_range();
                    PH_SUF:               close_suffix_range();
                    PH_WS_LAST, PH_WS_SUF: ;
                    default:              parse_broken = 1'b1;
                endcase
            end
        end
        if (scan_count < MIN_LEN)
            scan_count++;
        r.range_valid = range_hit && !parse_broken;
        r.range_start = r.range_valid ? range_lo[FIELD_BITS-1:0] : '0;
        r.range_end   = r.range_valid ? range_hi[FIELD_BITS-1:0] : '0;
        r.done_res    = fin;
        r.accepted    = fin && !parse_broken;
        if (fin)
        begin
            scan_phase   = PH_PREFIX;
            scan_count   = 0;
            first_num    = '0;
            last_num     = '0;
            suffix_num   = '0;
            ranges_taken = 0;
            parse_broken = 1'b0;
        end
        return r;
    endfunction

    task automatic append_text(input string s);
        for (int i = 0; i < s.len(); i++)
            draft.push_back(s[i]);
    endtask

    task automatic append_blank();
        if ($urandom_range(3, 0) == 0)
        begin
            repeat ($urandom_range(2, 1))
                draft.push_back($urandom_range(1, 0) ? CH_SPACE : CH_TAB);
        end
    endtask

    task automatic commit_draft();
        header_byte_t hb;
        for (int i = 0; i < draft.size(); i++)
        begin
            hb.ch  = draft[i];
            hb.fin = (i == draft.size() - 1);
            pending_bytes.push_back(hb);
        end
        bytes_queued += draft.size();
        draft.delete();
    endtask

    task automatic queue_text(input string s);
        append_text(s);
        commit_draft();
    endtask

    function automatic string num_text(input logic [63:0] v);
        string s;
        s = $sformatf("%0d", v);
        if ($urandom_range(19, 0) == 0)
            s = {"00", s};
        return s;
    endfunction

    // Offsets cluster around the configured size, with rare values past the offset width.
    function automatic logic [63:0] pick_offset();
        logic [63:0] wide;
        wide = {$urandom, $urandom};
        case ($urandom_range(31, 0))
            0, 1, 2, 3: return $urandom_range(9, 0);
            4, 5, 6, 7: return (resource_size == 0) ? 64'd0
                                                    : resource_size + $urandom_range(2, 0) - 1;
            8:          return OFFSET_MAX;
            9:          return wide & OFFSET_MAX;
            10:         return wide[0] ? OFFSET_MAX + 1 : wide;
            default:    return wide % (resource_size * 2 + 16);
        endcase
    endfunction

    // Mostly well-formed headers with random content; some noise and damaged ones.
    task automatic compose_header();
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] t;
        logic [7:0]  ch;
        int          specs;
        int          keep;
        if ($urandom_range(19, 0) == 0)
        begin
            repeat ($urandom_range(12, 1))
                draft.push_back(8'($urandom_range(255, 0)));
        end
        else
        begin
            for (int i = 0; i < PREFIX_LEN; i++)
            begin
                ch = UNIT_WORD[39 - 8 * i -: 8];
                draft.push_back($urandom_range(1, 0) ? (ch ^ CASE_BIT) : ch);
            end
            append_blank();
            draft.push_back(CH_EQ);
            append_blank();
            specs = ($urandom_range(9, 0) == 0)
                    ? $urandom_range(MAX_RANGE_COUNT_DEF + 2, MAX_RANGE_COUNT_DEF - 1)
                    : $urandom_range(4, 1);
            for (int k = 0; k < specs; k++)
            begin
                if (k != 0)
                begin
                    append_blank();
                    draft.push_back(CH_COMMA);
                    append_blank();
                end
                case ($urandom_range(2, 0))
                    0:
                    begin
                        a = pick_offset();
                        b = pick_offset();
                        if (b < a && $urandom_range(19, 0) != 0)
                        begin
                            t = a;
                            a = b;
                            b = t;
                        end
                        append_text(num_text(a));
                        append_blank();
                        draft.push_back(CH_DASH);
                        append_blank();
                        append_text(num_text(b));
                    end
                    1:
                    begin
                        append_text(num_text(pick_offset()));
                        append_blank();
                        draft.push_back(CH_DASH);
                    end
                    default:
                    begin
                        draft.push_back(CH_DASH);
                        append_blank();
                        append_text(num_text(pick_offset()));
                    end
                endcase
            end
            if ($urandom_range(3, 0) == 0)
                append_blank();
            if ($urandom_range(29, 0) == 0)
                draft.push_back(CH_COMMA);
            if ($urandom_range(11, 0) == 0)
                draft[$urandom_range(draft.size() - 1, 0)] = 8'($urandom_range(255, 0));
            if ($urandom_range(29, 0) == 0)
            begin
                keep = $urandom_range(6, 1);
                while (draft.size() > keep)
                    void'(draft.pop_back());
            end
        end
        commit_draft();
    endtask

    task automatic load_file_size(input logic [FIELD_BITS-1:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        file_size <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        resource_size = v;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_bytes.size() != 0 || in_valid || expected_results.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    // Sender: the gap after each transaction is drawn when the byte is put up.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            value_byte <= '0;
            last_byte  <= 1'b0;
            send_gap   <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_results.push_back(predict_range_result(value_byte, last_byte));
            if (!in_valid || in_ready)
            begin
                if (send_gap != 0)
                begin
                    in_valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (pending_bytes.size() != 0)
                begin
                    in_valid   <= 1'b1;
                    value_byte <= pending_bytes[0].ch;
                    last_byte  <= pending_bytes[0].fin;
                    void'(pending_bytes.pop_front());
                    send_gap   <= $urandom_range(in_gap_max, 0);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver: checks each result transaction and paces out_ready.
    always @(posedge clk or negedge rst_n)
    begin : result_side
        result_t want;
        int      pause;
        if (!rst_n)
        begin
            out_ready    <= 1'b0;
            rx_wait      <= 0;
            stall_left   <= 0;
            stalls_begun <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result: valid=%0d start=%0d end=%0d done=%0d acc=%0d",
                                 range_valid, range_start, range_end, done_res, accepted);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (range_valid !== want.range_valid || range_start !== want.range_start ||
                        range_end !== want.range_end || done_res !== want.done_res ||
                        accepted !== want.accepted)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            $display("mismatch: got  valid=%0d start=%0d end=%0d done=%0d acc=%0d",
                                     range_valid, range_start, range_end, done_res, accepted);
                            $display("          want valid=%0d start=%0d end=%0d done=%0d acc=%0d",
                                     want.range_valid, want.range_start, want.range_end,
                                     want.done_res, want.accepted);
                        end
                    end
                end
            end
            if (stalls_begun != stall_requests)
            begin
                // Long hold so that the pipeline backs up into the input side.
                stalls_begun <= stall_requests;
                stall_left   <= LONG_STALL;
                out_ready    <= 1'b0;
            end
            else if (stall_left != 0)
            begin
                stall_left <= stall_left - 1;
                out_ready  <= (stall_left == 1);
            end
            else if (out_valid && out_ready)
            begin
                pause = $urandom_range(out_wait_max, 0);
                rx_wait   <= pause;
                out_ready <= (pause == 0);
            end
            else if (rx_wait != 0)
            begin
                rx_wait   <= rx_wait - 1;
                out_ready <= (rx_wait == 1);
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("tb_top NOT OK");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        logic [FIELD_BITS-1:0] size_pick;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // With the reset size of zero nothing can be satisfied.
        queue_text("bytes=0-5");
        wait_drained();

        load_file_size(1000);
        queue_text("bytes=0-499");
        queue_text("Bytes \t= 500- , -200,\t0 - 0 ,990-5000");
        queue_text("bYtEs=-5000,1000-,-0");
        queue_text("bytes=9-3");
        queue_text("bytes=0-281474976710656");
        queue_text("bytes=281474976710655-");
        queue_text("bytes=");
        queue_text("bytes=1-2,");
        queue_text("bytez=1-2");
        queue_text("b");
        append_text("bytes=");
        for (int i = 0; i <= MAX_RANGE_COUNT_DEF; i++)
        begin
            if (i != 0)
                draft.push_back(CH_COMMA);
            append_text("-1");
        end
        commit_draft();
        draft.push_back(8'h00);
        draft.push_back(8'hFF);
        commit_draft();
        wait_drained();

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0:       size_pick = '0;
                1:       size_pick = 1;
                2:       size_pick = FIELD_BITS'(OFFSET_MAX);
                3:       size_pick = 500;
                4:       size_pick = $urandom_range(64, 2);
                5:       size_pick = $urandom;
                6:       size_pick = FIELD_BITS'({$urandom, $urandom});
                default: size_pick = $urandom_range(5000, 100);
            endcase
            load_file_size(size_pick);
            in_gap_max   = (ph % 4 == 0 || ph % 4 == 2) ? 5 : 0;
            out_wait_max = (ph % 4 == 0 || ph % 4 == 1) ? 5 : 0;
            if (ph == 3)
                stall_requests++;
            bytes_queued = 0;
            while (bytes_queued < PHASE_BYTES)
                compose_header();
            wait_drained();
        end

        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
